### rtl/arma_pkg.sv
// Shared types, constants and helper functions for the ASCII reading moving average.
package arma_pkg;

	localparam int WINDOW_LEN  = 32;
	localparam int FRAME_CHARS = 5;
	localparam int QUEUE_DEPTH = 2;

	localparam int CHAR_W    = 8;
	localparam int READING_W = 14;
	localparam int DIGIT_W   = 6;
	localparam int HELD_W    = 6;
	localparam int POS_W     = $clog2(FRAME_CHARS);
	localparam int PTR_W     = $clog2(WINDOW_LEN);
	localparam int CNT_W     = $clog2(WINDOW_LEN + 1);
	localparam int SUM_W     = READING_W + PTR_W;
	localparam int STEP_W    = $clog2(SUM_W);
	localparam int BCD_W     = 16;
	localparam int QPTR_W    = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W    = $clog2(QUEUE_DEPTH + 1);
	localparam int OUT_DATA_W = 48;

	localparam logic [POS_W-1:0]   LAST_POS   = POS_W'(FRAME_CHARS - 1);
	localparam logic [CNT_W-1:0]   WINDOW_CNT = CNT_W'(WINDOW_LEN);
	localparam logic [PTR_W-1:0]   LAST_SLOT  = PTR_W'(WINDOW_LEN - 1);
	localparam logic [DIGIT_W-1:0] ASCII_ZERO = DIGIT_W'(48);
	localparam logic [CHAR_W-1:0]  CHAR_ZERO  = CHAR_W'(48);

	typedef struct packed {
		logic [READING_W-1:0] value;
		logic                 bad;
	} reading_t;

	typedef enum logic [2:0] {
		BK_IDLE,
		BK_UPDATE,
		BK_DIV,
		BK_CONV,
		BK_EMIT
	} back_state_t;

	// One shift-and-add-3 step of the binary to BCD conversion.
	function automatic logic [BCD_W+READING_W-1:0] dabble_step(
		input logic [BCD_W+READING_W-1:0] v
	);
		logic [BCD_W+READING_W-1:0] a;
		a = v;
		for (int i = 0; i < BCD_W / 4; i++) begin
			if (a[READING_W + 4*i +: 4] >= 4'd5) begin
				a[READING_W + 4*i +: 4] = a[READING_W + 4*i +: 4] + 4'd3;
			end
		end
		return {a[BCD_W+READING_W-2:0], 1'b0};
	endfunction

	function automatic logic [DIGIT_W-1:0] ascii_of(input logic [3:0] d);
		return ASCII_ZERO + DIGIT_W'(d);
	endfunction

endpackage

### rtl/ascii_reading_moving_average.sv
// Top level of the ASCII reading moving average: parser, reading queue and averaging engine.
// Input characters are taken one per cycle; only the fifth character of a frame waits for queue room.
// After the fifth character is taken, a result is built in these steps: the reading is taken
// from the queue, the window is updated, a restoring divide runs (one quotient bit per cycle),
// binary to BCD conversion follows and the output register is loaded.
// The averaging engine accepts a new reading only when idle; a two-entry queue buffers readings.
// Reset (arst_n low) clears parser, queue, window count, sum and pointer; the window RAM is not cleared.
module ascii_reading_moving_average import arma_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_axis_tvalid,
	output logic                  s_axis_tready,
	// [7:0] rx_char
	input  logic [CHAR_W-1:0]     s_axis_tdata,
	output logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	// [13:0] average_hundredths, [19:14] digit_hundredths, [25:20] digit_tenths,
	// [31:26] digit_units, [37:32] digit_tens, [43:38] samples_held, [47:44] zero
	output logic [OUT_DATA_W-1:0] m_axis_tdata,
	// [0] reading_invalid
	output logic [0:0]            m_axis_tuser
);

	logic                 f_valid;
	logic                 f_ready;
	reading_t             f_data;
	logic                 q_valid;
	logic                 q_ready;
	reading_t             q_data;
	logic [READING_W-1:0] average_hundredths;
	logic [DIGIT_W-1:0]   digit_hundredths;
	logic [DIGIT_W-1:0]   digit_tenths;
	logic [DIGIT_W-1:0]   digit_units;
	logic [DIGIT_W-1:0]   digit_tens;
	logic [HELD_W-1:0]    samples_held;
	logic                 reading_invalid;

	arma_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.char_valid(s_axis_tvalid),
		.char_ready(s_axis_tready),
		.char_data (s_axis_tdata),
		.rd_valid  (f_valid),
		.rd_ready  (f_ready),
		.rd_data   (f_data)
	);

	arma_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_valid(f_valid),
		.push_ready(f_ready),
		.push_data (f_data),
		.pop_valid (q_valid),
		.pop_ready (q_ready),
		.pop_data  (q_data)
	);

	arma_back u_back (
		.clk               (clk),
		.arst_n            (arst_n),
		.rd_valid          (q_valid),
		.rd_ready          (q_ready),
		.rd_data           (q_data),
		.out_valid         (m_axis_tvalid),
		.out_ready         (m_axis_tready),
		.average_hundredths(average_hundredths),
		.digit_hundredths  (digit_hundredths),
		.digit_tenths      (digit_tenths),
		.digit_units       (digit_units),
		.digit_tens        (digit_tens),
		.samples_held      (samples_held),
		.reading_invalid   (reading_invalid)
	);

	assign m_axis_tdata = {4'b0000, samples_held, digit_tens, digit_units, digit_tenths,
		digit_hundredths, average_hundredths};
	assign m_axis_tuser = reading_invalid;

endmodule

### rtl/arma_ram.sv
// Generic single-write, single-read RAM with registered read data.
module arma_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

### rtl/arma_front.sv
// Character parser that assembles four digit characters into one reading.
module arma_front import arma_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              char_valid,
	output logic              char_ready,
	input  logic [CHAR_W-1:0] char_data,
	output logic              rd_valid,
	input  logic              rd_ready,
	output reading_t          rd_data
);

	logic [POS_W-1:0]     pos_q;
	logic [READING_W-1:0] accum_q;
	logic                 bad_q;
	logic                 is_digit;
	logic [3:0]           digit;
	logic                 accept;
	logic                 at_last;

	assign at_last    = (pos_q == LAST_POS);
	assign char_ready = !at_last || rd_ready;
	assign accept     = char_valid && char_ready;
	assign rd_valid   = char_valid && at_last;
	assign rd_data    = '{value: accum_q, bad: bad_q};

	always_comb begin
		is_digit = char_data inside {[8'd48:8'd57]};
		digit    = is_digit ? 4'(char_data - CHAR_ZERO) : 4'd0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q   <= '0;
			accum_q <= '0;
			bad_q   <= 1'b0;
		end else if (accept) begin
			if (at_last) begin
				pos_q   <= '0;
				accum_q <= '0;
				bad_q   <= 1'b0;
			end else begin
				pos_q   <= pos_q + 1'b1;
				accum_q <= READING_W'(accum_q * 4'd10 + READING_W'(digit));
				bad_q   <= bad_q || !is_digit;
			end
		end
	end

endmodule

### rtl/arma_queue.sv
// Small FIFO of finished readings between the parser and the averaging engine.
module arma_queue import arma_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     push_valid,
	output logic     push_ready,
	input  reading_t push_data,
	output logic     pop_valid,
	input  logic     pop_ready,
	output reading_t pop_data
);

	reading_t          entry_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wptr_q;
	logic [QPTR_W-1:0] rptr_q;
	logic [QCNT_W-1:0] count_q;
	logic              push;
	logic              pop;

	assign push_ready = (count_q != QCNT_W'(QUEUE_DEPTH));
	assign pop_valid  = (count_q != '0);
	assign pop_data   = entry_q[rptr_q];
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wptr_q <= (wptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wptr_q + 1'b1;
			end
			if (pop) begin
				rptr_q <= (rptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

### rtl/arma_back.sv
// Averaging engine: window ring update, serial divide, BCD conversion and output register.
module arma_back import arma_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  rd_valid,
	output logic                  rd_ready,
	input  reading_t              rd_data,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [READING_W-1:0]  average_hundredths,
	output logic [DIGIT_W-1:0]    digit_hundredths,
	output logic [DIGIT_W-1:0]    digit_tenths,
	output logic [DIGIT_W-1:0]    digit_units,
	output logic [DIGIT_W-1:0]    digit_tens,
	output logic [HELD_W-1:0]     samples_held,
	output logic                  reading_invalid
);

	back_state_t state_q, state_d;

	logic [READING_W-1:0]       reading_q;
	logic                       bad_q;
	logic [PTR_W-1:0]           wptr_q;
	logic [CNT_W-1:0]           fill_q;
	logic [SUM_W-1:0]           sum_q;
	logic [SUM_W-1:0]           quo_q;
	logic [CNT_W-1:0]           rem_q;
	logic [STEP_W-1:0]          step_q;
	logic [BCD_W+READING_W-1:0] dd_q;
	logic [READING_W-1:0]       avg_q;
	logic                       out_valid_q;

	logic                       ram_we;
	logic [READING_W-1:0]       old_value;
	logic                       full;
	logic [CNT_W:0]             trial;
	logic                       fits;
	logic                       load_out;
	logic [BCD_W-1:0]           bcd;

	arma_ram #(
		.WIDTH(READING_W),
		.DEPTH(WINDOW_LEN)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(wptr_q),
		.wdata(reading_q),
		.raddr(wptr_q),
		.rdata(old_value)
	);

	assign full     = (fill_q == WINDOW_CNT);
	assign trial    = {rem_q, quo_q[SUM_W-1]};
	assign fits     = (trial >= {1'b0, fill_q});
	assign bcd      = dd_q[BCD_W+READING_W-1:READING_W];
	assign rd_ready = (state_q == BK_IDLE);

	always_comb begin
		state_d  = state_q;
		ram_we   = 1'b0;
		load_out = 1'b0;
		case (state_q)
			BK_IDLE: begin
				if (rd_valid) begin
					state_d = BK_UPDATE;
				end
			end
			BK_UPDATE: begin
				ram_we  = 1'b1;
				state_d = BK_DIV;
			end
			BK_DIV: begin
				if (step_q == '0) begin
					state_d = BK_CONV;
				end
			end
			BK_CONV: begin
				if (step_q == '0) begin
					state_d = BK_EMIT;
				end
			end
			BK_EMIT: begin
				if (!out_valid_q || out_ready) begin
					load_out = 1'b1;
					state_d  = BK_IDLE;
				end
			end
			default: begin
				state_d = BK_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BK_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q      <= '0;
			fill_q      <= '0;
			sum_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == BK_UPDATE) begin
				wptr_q <= (wptr_q == LAST_SLOT) ? '0 : wptr_q + 1'b1;
				if (full) begin
					sum_q <= sum_q - SUM_W'(old_value) + SUM_W'(reading_q);
				end else begin
					sum_q  <= sum_q + SUM_W'(reading_q);
					fill_q <= fill_q + 1'b1;
				end
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			BK_IDLE: begin
				reading_q <= rd_data.value;
				bad_q     <= rd_data.bad;
			end
			BK_UPDATE: begin
				quo_q  <= full ? sum_q - SUM_W'(old_value) + SUM_W'(reading_q)
				               : sum_q + SUM_W'(reading_q);
				rem_q  <= '0;
				step_q <= STEP_W'(SUM_W - 1);
			end
			BK_DIV: begin
				quo_q <= {quo_q[SUM_W-2:0], fits};
				rem_q <= fits ? CNT_W'(trial - {1'b0, fill_q}) : CNT_W'(trial);
				if (step_q == '0) begin
					dd_q   <= {{BCD_W{1'b0}}, READING_W'({quo_q[SUM_W-2:0], fits})};
					step_q <= STEP_W'(READING_W - 1);
				end else begin
					step_q <= step_q - 1'b1;
				end
			end
			BK_CONV: begin
				dd_q  <= dabble_step(dd_q);
				avg_q <= READING_W'(quo_q);
				if (step_q != '0) begin
					step_q <= step_q - 1'b1;
				end
			end
			BK_EMIT: begin
				if (load_out) begin
					average_hundredths <= avg_q;
					digit_hundredths   <= ascii_of(bcd[3:0]);
					digit_tenths       <= ascii_of(bcd[7:4]);
					digit_units        <= ascii_of(bcd[11:8]);
					digit_tens         <= ascii_of(bcd[15:12]);
					samples_held       <= HELD_W'(fill_q);
					reading_invalid    <= bad_q;
				end
			end
			default: begin
			end
		endcase
	end

	assign out_valid = out_valid_q;

endmodule

### tb/ascii_reading_moving_average_tb.sv
// Self-checking testbench for the ASCII reading moving average: character frames in, checked averages out.
module ascii_reading_moving_average_tb;
	import arma_pkg::*;

	typedef struct {
		logic [READING_W-1:0] average;
		logic [DIGIT_W-1:0]   dig_hundredths;
		logic [DIGIT_W-1:0]   dig_tenths;
		logic [DIGIT_W-1:0]   dig_units;
		logic [DIGIT_W-1:0]   dig_tens;
		logic [HELD_W-1:0]    held;
		logic                 invalid;
	} average_report_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  s_axis_tvalid = 1'b0;
	logic                  s_axis_tready;
	logic [CHAR_W-1:0]     s_axis_tdata = '0;
	logic                  m_axis_tvalid;
	logic                  m_axis_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_axis_tdata;
	logic [0:0]            m_axis_tuser;

	logic [CHAR_W-1:0] rx_backlog[$];
	average_report_t   expected_averages[$];

	int                frame_pos = 0;
	logic [READING_W-1:0] frame_value = '0;
	logic              frame_bad = 1'b0;
	logic [READING_W-1:0] ring[WINDOW_LEN];
	logic [PTR_W-1:0]  ring_ptr = '0;
	int                window_fill = 0;
	int                window_total = 0;

	bit char_taken = 1'b0;
	bit quiet_tail = 1'b0;
	int send_gap = 0;
	int sink_gap = 0;
	int errors = 0;
	int chars_sent = 0;
	int frames_sent = 0;
	int bad_frames = 0;
	int averages_checked = 0;
	int peak_average = 0;

	ascii_reading_moving_average u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tuser(m_axis_tuser)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	task automatic absorb_char(input logic [CHAR_W-1:0] ch);
		average_report_t rep;
		logic [3:0]      d;
		int              avg;
		if (frame_pos < FRAME_CHARS - 1) begin
			d = 4'd0;
			if (ch >= CHAR_ZERO && ch <= CHAR_ZERO + 8'd9) begin
				d = 4'(ch - CHAR_ZERO);
			end else begin
				frame_bad = 1'b1;
			end
			frame_value = READING_W'(frame_value * 10 + d);
			frame_pos++;
		end else begin
			if (window_fill == WINDOW_LEN) begin
				window_total -= int'(ring[ring_ptr]);
			end else begin
				window_fill++;
			end
			ring[ring_ptr] = frame_value;
			window_total += int'(frame_value);
			ring_ptr = ring_ptr + 1'b1;
			avg = window_total / window_fill;
			if (avg > peak_average) begin
				peak_average = avg;
			end
			rep.average        = READING_W'(avg);
			rep.dig_hundredths = DIGIT_W'(48 + avg % 10);
			rep.dig_tenths     = DIGIT_W'(48 + (avg / 10) % 10);
			rep.dig_units      = DIGIT_W'(48 + (avg / 100) % 10);
			rep.dig_tens       = DIGIT_W'(48 + (avg / 1000) % 10);
			rep.held           = HELD_W'(window_fill);
			rep.invalid        = frame_bad;
			expected_averages.push_back(rep);
			if (frame_bad) begin
				bad_frames++;
			end
			frame_pos = 0;
			frame_value = '0;
			frame_bad = 1'b0;
		end
	endtask

	function automatic void compare_field(input string label, input int want, input int got);
		if (want != got) begin
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, label, want, got);
			errors++;
		end
	endfunction

	always @(posedge clk) begin
		average_report_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (expected_averages.size() == 0) begin
				$display("%0t: unexpected word, expected none, actual %h / %b", $time,
					m_axis_tdata, m_axis_tuser);
				errors++;
			end else begin
				want = expected_averages.pop_front();
				compare_field("average_hundredths", int'(want.average),
					int'(m_axis_tdata[13:0]));
				compare_field("digit_hundredths", int'(want.dig_hundredths),
					int'(m_axis_tdata[19:14]));
				compare_field("digit_tenths", int'(want.dig_tenths),
					int'(m_axis_tdata[25:20]));
				compare_field("digit_units", int'(want.dig_units),
					int'(m_axis_tdata[31:26]));
				compare_field("digit_tens", int'(want.dig_tens),
					int'(m_axis_tdata[37:32]));
				compare_field("samples_held", int'(want.held),
					int'(m_axis_tdata[43:38]));
				compare_field("reading_invalid", int'(want.invalid),
					int'(m_axis_tuser[0]));
				averages_checked++;
			end
		end
		char_taken = arst_n && s_axis_tvalid && s_axis_tready;
		if (char_taken) begin
			absorb_char(s_axis_tdata);
			chars_sent++;
		end
	end

	always @(negedge clk) begin
		if (arst_n && (!s_axis_tvalid || char_taken)) begin
			if (send_gap > 0) begin
				s_axis_tvalid <= 1'b0;
				send_gap <= send_gap - 1;
			end else if (rx_backlog.size() > 0) begin
				s_axis_tvalid <= 1'b1;
				s_axis_tdata <= rx_backlog.pop_front();
				if (!quiet_tail && $urandom_range(0, 9) == 0) begin
					send_gap <= $urandom_range(1, 5);
				end
			end else begin
				s_axis_tvalid <= 1'b0;
			end
		end
	end

	always @(negedge clk) begin
		if (arst_n) begin
			if (sink_gap > 0) begin
				m_axis_tready <= 1'b0;
				sink_gap <= sink_gap - 1;
			end else begin
				m_axis_tready <= 1'b1;
				if (!quiet_tail && $urandom_range(0, 7) == 0) begin
					sink_gap <= $urandom_range(1, 5);
				end
			end
		end
	end

	task automatic queue_frame(input logic [CHAR_W-1:0] c0, input logic [CHAR_W-1:0] c1,
		input logic [CHAR_W-1:0] c2, input logic [CHAR_W-1:0] c3, input logic [CHAR_W-1:0] sep);
		rx_backlog.push_back(c0);
		rx_backlog.push_back(c1);
		rx_backlog.push_back(c2);
		rx_backlog.push_back(c3);
		rx_backlog.push_back(sep);
		frames_sent++;
	endtask

	function automatic logic [CHAR_W-1:0] reading_char();
		if ($urandom_range(0, 19) == 0) begin
			return CHAR_W'($urandom_range(0, 255));
		end
		return CHAR_ZERO + CHAR_W'($urandom_range(0, 9));
	endfunction

	task automatic queue_random_frame();
		if ($urandom_range(0, 9) == 0) begin
			queue_frame(CHAR_W'($urandom_range(0, 255)), CHAR_W'($urandom_range(0, 255)),
				CHAR_W'($urandom_range(0, 255)), CHAR_W'($urandom_range(0, 255)),
				CHAR_W'($urandom_range(0, 255)));
		end else begin
			queue_frame(reading_char(), reading_char(), reading_char(), reading_char(),
				CHAR_W'($urandom_range(0, 255)));
		end
	endtask

	task automatic drain();
		while (rx_backlog.size() > 0 || s_axis_tvalid || expected_averages.size() > 0) begin
			@(posedge clk);
		end
	endtask

	initial begin
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		queue_frame("0", "0", "0", "0", 8'h00);
		queue_frame("9", "9", "9", "9", 8'hFF);
		queue_frame("/", ":", 8'h00, 8'hFF, ",");
		queue_frame("1", "2", "a", "7", " ");
		queue_frame("5", "0", "0", "0", 8'h0A);
		drain();

		repeat (150) queue_random_frame();
		drain();

		quiet_tail = 1'b1;
		repeat (34) queue_frame("9", "9", "9", "9", "\r");
		repeat (3) queue_random_frame();
		drain();
		repeat (60) @(posedge clk);

		$display("Run covered %0d characters in %0d frames, %0d of them with bad digits.",
			chars_sent, frames_sent, bad_frames);
		$display("Checked %0d averages, largest average %0d hundredths.",
			averages_checked, peak_average);
		if (errors == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

	initial begin
		#2000000;
		$display("Some tests failed");
		$finish;
	end

endmodule

### ascii_reading_moving_average.f
rtl/arma_pkg.sv
rtl/arma_ram.sv
rtl/arma_front.sv
rtl/arma_queue.sv
rtl/arma_back.sv
rtl/ascii_reading_moving_average.sv
tb/ascii_reading_moving_average_tb.sv
